// File: sv/nsdt_pkg.sv
// Shared types, constants and helpers for the name to sector directory table.
// No dependencies; every other file of the block imports this package.
package nsdt_pkg;

  localparam int ENTRIES      = 16;
  localparam int NAME_BYTES   = 9;
  localparam int SECTOR_COUNT = 1024;

  localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CMD_W    = 2;
  localparam int LOW_W    = 64;
  localparam int HIGH_W   = 8;
  localparam int NAME_W   = LOW_W + HIGH_W;
  localparam int SECTOR_W = 10;
  localparam int STATUS_W = 2;
  localparam int HIT_W    = 4;

  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  // Search token that walks the cell chain, one cell per cycle.
  typedef struct packed {
    logic                live;
    logic [NAME_W-1:0]   name;
    logic                found;
    logic [IDX_W-1:0]    hit_idx;
    logic [SECTOR_W-1:0] sector;
    logic                is_dir;
    logic                free_found;
    logic [IDX_W-1:0]    free_idx;
    logic                other_valid;   // a valid entry other than the hit
  } nsdt_token_t;

  // Write command broadcast to all cells after the scan.
  typedef struct packed {
    logic                add;
    logic                clr;
    logic [IDX_W-1:0]    idx;
    logic [NAME_W-1:0]   name;
    logic [SECTOR_W-1:0] sector;
    logic                is_dir;
  } nsdt_wr_t;

  // Clear every byte from the first zero byte on, and bytes past NAME_BYTES.
  // Stored names are kept in this form, so a match is plain equality.
  function automatic logic [NAME_W-1:0] norm_name(logic [LOW_W-1:0] lo,
                                                  logic [HIGH_W-1:0] hi);
    logic [NAME_W-1:0] raw;
    logic [NAME_W-1:0] res;
    logic              stop;
    raw  = {hi, lo};
    res  = '0;
    stop = 1'b0;
    for (int k = 0; k < NAME_BYTES; k++) begin
      if (raw[8*k +: 8] == 8'd0) stop = 1'b1;
      if (!stop) res[8*k +: 8] = raw[8*k +: 8];
    end
    return res;
  endfunction

  function automatic logic [HIT_W-1:0] to_hit(logic [IDX_W-1:0] idx);
    logic [HIT_W-1:0] res;
    res = '0;
    for (int j = 0; j < HIT_W; j++) begin
      if (j < IDX_W) res[j] = idx[j];
    end
    return res;
  endfunction

endpackage

// File: sv/nsdt_req_if.sv
// Request channel: valid/ready handshake carrying one command item.
// Depends on nsdt_pkg for field widths.
interface nsdt_req_if import nsdt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [LOW_W-1:0]    name_low;
  logic [HIGH_W-1:0]   name_high;
  logic [SECTOR_W-1:0] new_sector;
  logic                new_is_dir;

  modport source(output valid, cmd, name_low, name_high, new_sector, new_is_dir,
                 input ready);
  modport sink(input valid, cmd, name_low, name_high, new_sector, new_is_dir,
               output ready);
endinterface

// File: sv/nsdt_rsp_if.sv
// Response channel: valid/ready handshake carrying one result item.
// Depends on nsdt_pkg for field widths.
interface nsdt_rsp_if import nsdt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [HIT_W-1:0]    hit_index;
  logic [SECTOR_W-1:0] found_sector;
  logic                found_is_dir;
  logic                table_empty;

  modport source(output valid, status, hit_index, found_sector, found_is_dir,
                 table_empty, input ready);
  modport sink(input valid, status, hit_index, found_sector, found_is_dir,
               table_empty, output ready);
endinterface

// File: sv/nsdt_cell.sv
// One directory entry plus one stage of the search token chain.
// Depends on nsdt_pkg (token and write types).
module nsdt_cell import nsdt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] pos,
  input  nsdt_token_t      tok_in,
  output nsdt_token_t      tok_out,
  input  nsdt_wr_t         wr
);

  logic                valid;
  logic [NAME_W-1:0]   name;
  logic [SECTOR_W-1:0] sector;
  logic                is_dir;

  logic        hit_here;
  logic        sel;
  nsdt_token_t tok_next;

  assign sel = (wr.idx == pos);

  always_comb begin
    tok_next = tok_in;
    hit_here = tok_in.live && valid && !tok_in.found && (name == tok_in.name);
    if (hit_here) begin
      tok_next.found   = 1'b1;
      tok_next.hit_idx = pos;
      tok_next.sector  = sector;
      tok_next.is_dir  = is_dir;
    end
    if (tok_in.live && !valid && !tok_in.free_found) begin
      tok_next.free_found = 1'b1;
      tok_next.free_idx   = pos;
    end
    if (tok_in.live && valid && !hit_here) tok_next.other_valid = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr.add && sel) begin
      valid <= 1'b1;
    end else if (wr.clr && sel) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.add && sel) begin
      name   <= wr.name;
      sector <= wr.sector;
      is_dir <= wr.is_dir;
    end
  end

endmodule

// File: sv/name_to_sector_directory_table_unit.sv
// Directory table of ENTRIES file entries: lookup, add and remove by name.
// A search token walks the row of entry cells one cell per cycle; then the
// finish state applies the add or remove and loads the result register once
// the previous result has been taken. One item is in work at a time; a new
// item is taken once the previous result has been loaded for output.
// Entry valid marks clear at reset; no other setup is needed.
// Depends on nsdt_pkg, nsdt_req_if, nsdt_rsp_if and nsdt_cell.
module name_to_sector_directory_table_unit import nsdt_pkg::*; (
  input logic       clk,
  input logic       rst,
  nsdt_req_if.sink  req,
  nsdt_rsp_if.source rsp
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  logic [CMD_W-1:0]    cmd;
  logic [SECTOR_W-1:0] new_sector;
  logic                new_is_dir;
  nsdt_token_t         tok0;
  nsdt_token_t         tok0_next;
  nsdt_token_t         res;
  nsdt_token_t         chain [ENTRIES+1];
  logic [ENTRIES:0]    live_vec;
  nsdt_wr_t            wr;

  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [HIT_W-1:0]    out_hit;
  logic [SECTOR_W-1:0] out_sector;
  logic                out_is_dir;
  logic                out_empty;

  logic                accept;
  logic                fire;
  logic [STATUS_W-1:0] r_status;
  logic [HIT_W-1:0]    r_hit;
  logic [SECTOR_W-1:0] r_sector;
  logic                r_is_dir;
  logic                r_empty;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign fire      = (state == S_FIN) && (!out_valid || rsp.ready);

  assign chain[0] = tok0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    nsdt_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .pos    (IDX_W'(i)),
      .tok_in (chain[i]),
      .tok_out(chain[i+1]),
      .wr     (wr)
    );
  end

  for (genvar i = 0; i <= ENTRIES; i++) begin : g_live
    assign live_vec[i] = chain[i].live;
  end

  always_comb begin
    tok0_next      = '0;
    tok0_next.live = accept;
    tok0_next.name = norm_name(req.name_low, req.name_high);
  end

  // Token injection: live for exactly one cycle after accept.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok0 <= '0;
    end else begin
      tok0 <= tok0_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd        <= req.cmd;
      new_sector <= req.new_sector;
      new_is_dir <= req.new_is_dir;
    end
    if (state == S_SCAN && chain[ENTRIES].live) res <= chain[ENTRIES];
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (accept) state_next = S_SCAN;
      S_SCAN: if (chain[ENTRIES].live) state_next = S_FIN;
      S_FIN:  if (fire) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Result and table update from the finished scan.
  always_comb begin
    r_status = ST_OK;
    r_hit    = '0;
    r_sector = '0;
    r_is_dir = 1'b0;
    r_empty  = !(res.found || res.other_valid);
    wr        = '0;
    wr.name   = res.name;
    wr.sector = new_sector;
    wr.is_dir = new_is_dir;
    wr.idx    = res.hit_idx;
    case (cmd)
      CMD_LOOKUP: begin
        if (res.found) begin
          r_hit    = to_hit(res.hit_idx);
          r_sector = res.sector;
          r_is_dir = res.is_dir;
        end else begin
          r_status = ST_NOT_FOUND;
        end
      end
      CMD_ADD: begin
        if (res.found) begin
          r_status = ST_PRESENT;
        end else if (res.free_found) begin
          r_hit   = to_hit(res.free_idx);
          r_empty = 1'b0;
          wr.idx  = res.free_idx;
          wr.add  = fire;
        end else begin
          r_status = ST_FULL;
        end
      end
      CMD_REMOVE: begin
        if (res.found) begin
          r_hit   = to_hit(res.hit_idx);
          r_empty = !res.other_valid;
          wr.clr  = fire;
        end else begin
          r_status = ST_NOT_FOUND;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_status <= r_status;
      out_hit    <= r_hit;
      out_sector <= r_sector;
      out_is_dir <= r_is_dir;
      out_empty  <= r_empty;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.hit_index    = out_hit;
  assign rsp.found_sector = out_sector;
  assign rsp.found_is_dir = out_is_dir;
  assign rsp.table_empty  = out_empty;

  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $countones(live_vec) <= 1)
    else $error("more than one search token in the chain");

  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_SCAN) && tok0.live)
    else $error("accepted item did not start a scan");

  a_add_free: assert property (@(posedge clk) disable iff (rst)
    wr.add |-> !res.found && res.free_found && !wr.clr)
    else $error("add written without a free entry or over a present name");

  a_clr_found: assert property (@(posedge clk) disable iff (rst)
    wr.clr |-> res.found && (wr.idx == res.hit_idx))
    else $error("remove written without a matching entry");

  a_idle_no_token: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |-> (live_vec == '0))
    else $error("token still in chain while finishing an item");

endmodule
